>>> hw/rtl/cgfp_pkg.sv
// cgfp_pkg: shared constants, micro-op codes and the control store for the
// centered grid formation point sequencer.
// No dependencies.
package cgfp_pkg;

  localparam int CNT_W     = 7;    // point_count width
  localparam int IDX_W     = 6;    // point index width
  localparam int POS_W     = 20;   // output coordinate width
  localparam int SPC_W     = 16;   // grid spacing width, Q8.8
  localparam int COL_W     = 4;    // column / row counter width
  localparam int SUM_W     = 8;    // summed index, at most 8 * 28
  localparam int DIVD_W    = 25;   // 2 * spacing * sum + n
  localparam int DIVS_W    = 8;    // divisor 2 * n
  localparam int BIT_W     = 5;    // divider bit counter
  localparam int STEP_W    = 4;
  localparam int MAX_POINTS  = 64;
  localparam logic [SPC_W-1:0] SPACING_RESET = 16'd256;

  typedef logic [STEP_W-1:0] step_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_ACCEPT,
    OP_SQRT,
    OP_SUM,
    OP_DIVX_LOAD,
    OP_DIV_STEP,
    OP_DIVY_LOAD,
    OP_EMIT_INIT,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NO_REQ,
    COND_SQRT_MORE,
    COND_SUM_MORE,
    COND_DIV_MORE,
    COND_EMIT_MORE
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
  } uop_t;

  localparam step_t STEP_IDLE  = 4'd0;
  localparam step_t STEP_SQRT  = 4'd1;
  localparam step_t STEP_SUM   = 4'd2;
  localparam step_t STEP_DIVXL = 4'd3;
  localparam step_t STEP_DIVX  = 4'd4;
  localparam step_t STEP_DIVYL = 4'd5;
  localparam step_t STEP_DIVY  = 4'd6;
  localparam step_t STEP_EINIT = 4'd7;
  localparam step_t STEP_EMIT  = 4'd8;
  localparam step_t STEP_END   = 4'd9;

  // control store: jump to target when the condition holds, else fall through
  function automatic uop_t prog_rom(input step_t s);
    uop_t u;
    case (s)
      STEP_IDLE:  u = '{OP_ACCEPT,    COND_NO_REQ,    STEP_IDLE};
      STEP_SQRT:  u = '{OP_SQRT,      COND_SQRT_MORE, STEP_SQRT};
      STEP_SUM:   u = '{OP_SUM,       COND_SUM_MORE,  STEP_SUM};
      STEP_DIVXL: u = '{OP_DIVX_LOAD, COND_NEVER,     STEP_IDLE};
      STEP_DIVX:  u = '{OP_DIV_STEP,  COND_DIV_MORE,  STEP_DIVX};
      STEP_DIVYL: u = '{OP_DIVY_LOAD, COND_NEVER,     STEP_IDLE};
      STEP_DIVY:  u = '{OP_DIV_STEP,  COND_DIV_MORE,  STEP_DIVY};
      STEP_EINIT: u = '{OP_EMIT_INIT, COND_NEVER,     STEP_IDLE};
      STEP_EMIT:  u = '{OP_EMIT,      COND_EMIT_MORE, STEP_EMIT};
      STEP_END:   u = '{OP_NOP,       COND_ALWAYS,    STEP_IDLE};
      default:    u = '{OP_NOP,       COND_ALWAYS,    STEP_IDLE};
    endcase
    return u;
  endfunction

endpackage

>>> hw/rtl/centered_grid_formation_points.sv
// centered_grid_formation_points: microcoded sequencer that turns a point count
// into centered grid positions, one result transaction per point.
// Depends on cgfp_pkg (micro-op codes, control store, widths).
// Sequence: after accept, the column count, the index sums and both centroid
// coordinates are formed before the first point appears at the output.
// Throughput: set by the shared bit-serial divider and the emit loop, one point
// per cycle while out_ready allows; no new request is accepted until it ends.
// Reset: synchronous, active high; returns to idle, drops out_valid, spacing = 1.0.
module centered_grid_formation_points
  import cgfp_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [SPC_W-1:0]        grid_spacing,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [CNT_W-1:0]        point_count,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [POS_W-1:0] pos_x,
  output logic signed [POS_W-1:0] pos_y,
  output logic [IDX_W-1:0]        point_index,
  output logic                    last_point
);

  step_t              step, step_next;
  uop_t               uop;
  logic [SPC_W-1:0]   spacing;
  logic [CNT_W-1:0]   n;
  logic [CNT_W-1:0]   n_sat;
  logic [COL_W-1:0]   cols;
  logic [COL_W-1:0]   col, row;
  logic [IDX_W-1:0]   idx;
  logic [SUM_W-1:0]   sum_c, sum_r;
  logic [DIVD_W-1:0]  quo;
  logic [DIVS_W-2:0]  rem;
  logic [DIVS_W-1:0]  divisor;
  logic [BIT_W-1:0]   bitcnt;
  logic [POS_W-1:0]   cent_x, cent_y;

  logic [2*COL_W-1:0] cols_sq;
  logic               sqrt_more, idx_last, col_wrap, load_out, cond_hit;
  logic [DIVS_W-1:0]  trial;
  logic               trial_ge;
  logic [SPC_W+SUM_W-1:0] prod_sum;
  logic [SUM_W-1:0]   sum_sel;

  assign uop       = prog_rom(step);
  assign in_ready  = (uop.op == OP_ACCEPT);
  assign cfg_ready = (uop.op == OP_ACCEPT);
  assign n_sat     = (point_count > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) : point_count;

  assign cols_sq   = cols * cols;
  assign sqrt_more = ({1'b0, cols_sq} < {{(2*COL_W+1-CNT_W){1'b0}}, n});
  assign idx_last  = ({1'b0, idx} + CNT_W'(1)) == n;
  assign col_wrap  = (col + COL_W'(1)) == cols;
  assign load_out  = !out_valid || out_ready;

  // restoring divider, one quotient bit per cycle
  assign trial    = {rem, quo[DIVD_W-1]};
  assign trial_ge = (trial >= divisor);

  assign sum_sel  = (uop.op == OP_DIVX_LOAD) ? sum_c : sum_r;
  assign prod_sum = spacing * sum_sel;

  always_comb begin
    case (uop.cond)
      COND_NEVER:     cond_hit = 1'b0;
      COND_ALWAYS:    cond_hit = 1'b1;
      COND_NO_REQ:    cond_hit = !in_valid || (n_sat == '0);
      COND_SQRT_MORE: cond_hit = sqrt_more;
      COND_SUM_MORE:  cond_hit = !idx_last;
      COND_DIV_MORE:  cond_hit = (bitcnt != BIT_W'(DIVD_W - 1));
      COND_EMIT_MORE: cond_hit = !(load_out && idx_last);
      default:        cond_hit = 1'b0;
    endcase
    step_next = cond_hit ? uop.target : step + STEP_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step    <= STEP_IDLE;
      spacing <= SPACING_RESET;
    end else begin
      step <= step_next;
      if (cfg_valid && cfg_ready) begin
        spacing <= grid_spacing;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (uop.op == OP_EMIT && load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // datapath driven by the current control word
  always_ff @(posedge clk) begin
    case (uop.op)
      OP_ACCEPT: begin
        n     <= n_sat;
        cols  <= COL_W'(1);
        col   <= '0;
        row   <= '0;
        idx   <= '0;
        sum_c <= '0;
        sum_r <= '0;
      end
      OP_SQRT: begin
        if (sqrt_more) begin
          cols <= cols + COL_W'(1);
        end
      end
      OP_SUM: begin
        sum_c <= sum_c + SUM_W'(col);
        sum_r <= sum_r + SUM_W'(row);
        idx   <= idx + IDX_W'(1);
        if (col_wrap) begin
          col <= '0;
          row <= row + COL_W'(1);
        end else begin
          col <= col + COL_W'(1);
        end
      end
      OP_DIVX_LOAD, OP_DIVY_LOAD: begin
        if (uop.op == OP_DIVY_LOAD) begin
          cent_x <= quo[POS_W-1:0];
        end
        quo     <= {prod_sum, 1'b0} + DIVD_W'(n);
        rem     <= '0;
        divisor <= {n, 1'b0};
        bitcnt  <= '0;
      end
      OP_DIV_STEP: begin
        rem    <= trial_ge ? (DIVS_W-1)'(trial - divisor) : trial[DIVS_W-2:0];
        quo    <= {quo[DIVD_W-2:0], trial_ge};
        bitcnt <= bitcnt + BIT_W'(1);
      end
      OP_EMIT_INIT: begin
        cent_y <= quo[POS_W-1:0];
        col    <= '0;
        row    <= '0;
        idx    <= '0;
      end
      OP_EMIT: begin
        if (load_out) begin
          pos_x       <= $signed(POS_W'(col) * POS_W'(spacing) - cent_x);
          pos_y       <= $signed(POS_W'(row) * POS_W'(spacing) - cent_y);
          point_index <= idx;
          last_point  <= idx_last;
          idx         <= idx + IDX_W'(1);
          if (col_wrap) begin
            col <= '0;
            row <= row + COL_W'(1);
          end else begin
            col <= col + COL_W'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

`ifndef SYNTH
  // column count is the ceiling square root once the sum loop starts
  a_sqrt_bound: assert property (@(posedge clk) disable iff (rst)
    (step == STEP_SUM) |->
      ({1'b0, cols_sq} >= {{(2*COL_W+1-CNT_W){1'b0}}, n}) &&
      (((cols - COL_W'(1)) * (cols - COL_W'(1))) < {{(2*COL_W-CNT_W){1'b0}}, n}))
    else $error("column count is not the ceiling square root");

  a_grid_walk: assert property (@(posedge clk) disable iff (rst)
    (step == STEP_SUM || step == STEP_EMIT) |-> (col < cols) && ({1'b0, idx} < n))
    else $error("grid walk left the formation");

  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    (step == STEP_DIVX || step == STEP_DIVY) |-> ({1'b0, rem} < divisor))
    else $error("divider remainder not below divisor");

  a_last_ends_run: assert property (@(posedge clk) disable iff (rst)
    (step == STEP_EMIT && load_out && idx_last) |=> out_valid && last_point &&
      (step == STEP_END))
    else $error("final point did not close the run");
`endif

endmodule
